### hw/rtl/mmcal_pkg.sv
// mmcal_pkg: shared types and constants for the magnetometer min/max calibration block
// no dependencies; imported by magnetometer_minmax_calibration
package mmcal_pkg;

  // field and state widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 8;
  localparam int unsigned ProdW   = SampleW + GainW + 1;   // signed sample * unsigned gain
  localparam int unsigned ExtW    = 26;                    // running extremes
  localparam int unsigned SpanW   = 25;                    // high - low, never negative
  localparam int unsigned NumW    = 31;                    // 100 * x span
  localparam int unsigned RemW    = SpanW + 1;             // divider partial remainder
  localparam int unsigned OffW    = 24;
  localparam int unsigned SumW    = ExtW + 1;
  localparam int unsigned DivCntW = $clog2(NumW);
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;

  // register map (index into the register list)
  localparam logic REG_GAIN = 1'b0;

  // reset values
  localparam logic [GainW-1:0]       GAIN_RESET = 8'd122;
  localparam logic signed [ExtW-1:0] LOW_RESET  = 26'sd100000;
  localparam logic signed [ExtW-1:0] HIGH_RESET = -26'sd100000;

  localparam logic [DivCntW-1:0] DIV_LAST = DivCntW'(NumW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } cal_state_t;

endpackage

### hw/rtl/magnetometer_minmax_calibration.sv
// magnetometer_minmax_calibration: hard-iron min/max tracking, offsets and soft scale ratio
// depends on mmcal_pkg (types, widths, reset values)
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   input   | in_valid / in_stall  | x_sample, y_sample
//   output  | out_valid / out_stall| scale_ratio, scale_valid, x_offset, y_offset
//   config  | apb psel/penable     | gain_hundredths at byte address 0
//
// a transaction runs from acceptance through the gain multiply, the extreme update and
// the span/offset prep, one state each, then the restoring divider (one quotient bit per
// cycle through a single subtractor), and ends by loading the output register once free.
// a zero y span skips the divider.
// in_stall is high from acceptance until the result sits in the output register, then low
// while idle until the next transaction is accepted. a result stalled downstream does not
// block acceptance of the next transaction; its result waits until the register is free.
// rst is synchronous: extremes go to +-100000, gain to 122, output register empties.
module magnetometer_minmax_calibration
  import mmcal_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SampleW-1:0] x_sample,
  input  logic signed [SampleW-1:0] y_sample,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [NumW-1:0]           scale_ratio,
  output logic                      scale_valid,
  output logic signed [OffW-1:0]    x_offset,
  output logic signed [OffW-1:0]    y_offset,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [PdataW-1:0]         pwdata,
  output logic [PdataW-1:0]         prdata,
  output logic                      pready
);

  cal_state_t state, state_next;

  // control outputs of the sequencer
  logic accept;
  logic load_out;
  logic div_skip;

  // configuration
  logic [GainW-1:0] gain;

  // sample and product registers
  logic signed [SampleW-1:0] x_in, y_in;
  logic signed [ProdW-1:0]   x_prod, y_prod;

  // running extremes in hundredths
  logic signed [ExtW-1:0] x_low, x_high, y_low, y_high;
  logic signed [ExtW-1:0] x_ext, y_ext;

  // spans and offsets
  logic signed [ExtW:0]   x_span_full, y_span_full;
  logic [SpanW-1:0]       x_span, y_span;
  logic [NumW-1:0]        x_span_100;
  logic signed [OffW-1:0] x_off_calc, y_off_calc;
  logic signed [OffW-1:0] x_off, y_off;
  logic                   ratio_ok;

  // divider datapath
  logic [NumW-1:0]    num;
  logic [SpanW-1:0]   den;
  logic [RemW-1:0]    rem;
  logic [DivCntW-1:0] div_cnt;
  logic [RemW-1:0]    rem_shift;
  logic [RemW:0]      rem_diff;
  logic               rem_ge;

  // apb: always ready, one register
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_GAIN) begin
      prdata = PdataW'(gain);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_GAIN)) begin
      gain <= pwdata[GainW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_PREP;
      ST_PREP: begin
        if (y_span == '0) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == DIV_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    load_out = 1'b0;
    div_skip = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_PREP: div_skip = (y_span == '0);
      ST_DONE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // gain multiply: signed sample times unsigned gain
  always_ff @(posedge clk) begin
    if (accept) begin
      x_in <= x_sample;
      y_in <= y_sample;
    end
    if (state == ST_MUL) begin
      x_prod <= ProdW'(x_in) * ProdW'($signed({1'b0, gain}));
      y_prod <= ProdW'(y_in) * ProdW'($signed({1'b0, gain}));
    end
  end

  assign x_ext = ExtW'(x_prod);
  assign y_ext = ExtW'(y_prod);

  // extreme tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= LOW_RESET;
      x_high <= HIGH_RESET;
      y_low  <= LOW_RESET;
      y_high <= HIGH_RESET;
    end else if (state == ST_UPD) begin
      if (x_ext < x_low)  x_low  <= x_ext;
      if (x_ext > x_high) x_high <= x_ext;
      if (y_ext < y_low)  y_low  <= y_ext;
      if (y_ext > y_high) y_high <= y_ext;
    end
  end

  // spans are never negative once a sample is in, so the low bits carry them
  assign x_span_full = (ExtW+1)'(x_high) - (ExtW+1)'(x_low);
  assign y_span_full = (ExtW+1)'(y_high) - (ExtW+1)'(y_low);
  assign x_span      = x_span_full[SpanW-1:0];
  assign y_span      = y_span_full[SpanW-1:0];

  // 100 = 64 + 32 + 4
  assign x_span_100 = (NumW'(x_span) << 6) + (NumW'(x_span) << 5) + (NumW'(x_span) << 2);

  // offset = -(high + low) / 2, halved toward zero
  function automatic logic signed [OffW-1:0] neg_half(
    input logic signed [ExtW-1:0] high,
    input logic signed [ExtW-1:0] low
  );
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] adj;
    logic signed [SumW-1:0] half;
    sum  = SumW'(high) + SumW'(low);
    adj  = sum + SumW'(sum[SumW-1]);
    half = adj >>> 1;
    return OffW'(-half);
  endfunction

  assign x_off_calc = neg_half(x_high, x_low);
  assign y_off_calc = neg_half(y_high, y_low);

  // one restoring divide step: shift in the next dividend bit, trial subtract
  assign rem_shift = {rem[RemW-2:0], num[NumW-1]};
  assign rem_diff  = {1'b0, rem_shift} - (RemW+1)'(den);
  assign rem_ge    = !rem_diff[RemW];

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      num      <= x_span_100;
      den      <= y_span;
      rem      <= '0;
      x_off    <= x_off_calc;
      y_off    <= y_off_calc;
      ratio_ok <= !div_skip;
    end else if (state == ST_DIV) begin
      // the dividend register fills with quotient bits from the bottom
      num <= {num[NumW-2:0], rem_ge};
      rem <= rem_ge ? rem_diff[RemW-1:0] : rem_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 1'b1;
    end else begin
      div_cnt <= '0;
    end
  end

  // output register, parts the divider from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      scale_ratio <= ratio_ok ? num : '0;
      scale_valid <= ratio_ok;
      x_offset    <= x_off;
      y_offset    <= y_off;
    end
  end

`ifndef SYNTHESIS
  // the divider never runs past its last quotient bit
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt <= DIV_LAST))
    else $error("divider step count out of range");

  // extremes are ordered once the update cycle has run
  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |-> ((x_high >= x_low) && (y_high >= y_low)))
    else $error("running extremes out of order");

  // an invalid scale always comes out as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !scale_valid) |-> (scale_ratio == '0))
    else $error("invalid scale with nonzero ratio");

  // an accepted transaction starts the multiply next cycle
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL))
    else $error("accepted transaction did not start");
`endif

endmodule

### bench/magnetometer_minmax_calibration_checker.sv
// checker for magnetometer_minmax_calibration: tracks gain and running extremes, predicts
// ratio/offsets per sample pair and compares them with the output channel; uses mmcal_pkg
module magnetometer_minmax_calibration_checker
  import mmcal_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [SampleW-1:0] x_sample,
  input  logic signed [SampleW-1:0] y_sample,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [NumW-1:0]           scale_ratio,
  input  logic                      scale_valid,
  input  logic signed [OffW-1:0]    x_offset,
  input  logic signed [OffW-1:0]    y_offset,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [PdataW-1:0]         pwdata,
  input  logic [PdataW-1:0]         prdata,
  input  logic                      pready,
  output int                        checked,
  output int                        mismatches,
  output int                        waiting,
  output int                        flat_spans
);

  localparam logic [PaddrW-1:0] GAIN_ADDR = PaddrW'({REG_GAIN, 2'b00});

  typedef struct packed {
    logic [NumW-1:0]        ratio;
    logic                   valid;
    logic signed [OffW-1:0] x_off;
    logic signed [OffW-1:0] y_off;
  } cal_result_t;

  logic [GainW-1:0] gain;
  longint           x_lo, x_hi, y_lo, y_hi;
  cal_result_t      pending_q[$];
  int               n_checked, n_bad, n_flat;

  function automatic cal_result_t calibrate(logic signed [SampleW-1:0] xs,
                                            logic signed [SampleW-1:0] ys);
    cal_result_t res;
    longint      xv, yv, xspan, yspan, xo, yo;
    xv = longint'(xs) * longint'(gain);
    yv = longint'(ys) * longint'(gain);
    if (xv < x_lo) x_lo = xv;
    if (yv < y_lo) y_lo = yv;
    if (xv > x_hi) x_hi = xv;
    if (yv > y_hi) y_hi = yv;
    xspan = x_hi - x_lo;
    yspan = y_hi - y_lo;
    res.ratio = '0;
    res.valid = (yspan != 0);
    if (yspan > 0 && xspan >= 0) begin
      xo = (100 * xspan) / yspan;
      res.ratio = xo[NumW-1:0];
    end
    // signed division truncates toward zero
    xo = -(x_hi + x_lo) / 2;
    yo = -(y_hi + y_lo) / 2;
    res.x_off = xo[OffW-1:0];
    res.y_off = yo[OffW-1:0];
    return res;
  endfunction

  task automatic flag_field(string name, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    n_bad++;
  endtask

  always @(posedge clk) begin
    cal_result_t want;
    if (rst) begin
      gain = GAIN_RESET;
      x_lo = longint'(LOW_RESET);
      y_lo = longint'(LOW_RESET);
      x_hi = longint'(HIGH_RESET);
      y_hi = longint'(HIGH_RESET);
      pending_q.delete();
      n_checked = 0;
      n_bad = 0;
      n_flat = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == GAIN_ADDR) gain = pwdata[GainW-1:0];
        end else if (paddr == GAIN_ADDR && prdata !== PdataW'(gain)) begin
          flag_field("gain readback", longint'(gain), longint'(prdata));
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result, expected nothing got ratio %0d", $time,
                   scale_ratio);
          n_bad++;
        end else begin
          want = pending_q.pop_front();
          if (scale_ratio !== want.ratio)
            flag_field("scale_ratio", longint'(want.ratio), longint'(scale_ratio));
          if (scale_valid !== want.valid)
            flag_field("scale_valid", longint'(want.valid), longint'(scale_valid));
          if (x_offset !== want.x_off)
            flag_field("x_offset", longint'(want.x_off), longint'(x_offset));
          if (y_offset !== want.y_off)
            flag_field("y_offset", longint'(want.y_off), longint'(y_offset));
          if (!want.valid) n_flat++;
          n_checked++;
        end
      end
      if (in_valid && !in_stall) pending_q.push_back(calibrate(x_sample, y_sample));
    end
    checked    <= n_checked;
    mismatches <= n_bad;
    waiting    <= pending_q.size();
    flat_spans <= n_flat;
  end

endmodule

### bench/magnetometer_minmax_calibration_tb.sv
// testbench top for magnetometer_minmax_calibration: stimulus, stall pattern and verdict
// depends on mmcal_pkg, the block and magnetometer_minmax_calibration_checker
module magnetometer_minmax_calibration_tb
  import mmcal_pkg::*;
();

  localparam logic [PaddrW-1:0] GAIN_ADDR  = PaddrW'({REG_GAIN, 2'b00});
  // first address past the register map, writes there must be dropped
  localparam logic [PaddrW-1:0] SPARE_ADDR = PaddrW'({~REG_GAIN, 2'b00});
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 40;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [SampleW-1:0] x_sample = '0;
  logic signed [SampleW-1:0] y_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [NumW-1:0]           scale_ratio;
  logic                      scale_valid;
  logic signed [OffW-1:0]    x_offset;
  logic signed [OffW-1:0]    y_offset;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PaddrW-1:0]         paddr = '0;
  logic [PdataW-1:0]         pwdata = '0;
  logic [PdataW-1:0]         prdata;
  logic                      pready;

  int checked, mismatches, waiting, flat_spans;
  int sent = 0;
  int gain_writes = 0;
  int cycles = 0;
  int stall_left = 0;
  // calm phases: no source gaps and no sink stalls
  logic calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  magnetometer_minmax_calibration dut (
    .clk, .rst,
    .in_valid, .in_stall, .x_sample, .y_sample,
    .out_valid, .out_stall, .scale_ratio, .scale_valid, .x_offset, .y_offset,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  magnetometer_minmax_calibration_checker checker_i (
    .clk, .rst,
    .in_valid, .in_stall, .x_sample, .y_sample,
    .out_valid, .out_stall, .scale_ratio, .scale_valid, .x_offset, .y_offset,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .checked, .mismatches, .waiting, .flat_spans
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // random reading, usually narrowed so the extremes keep growing phase by phase;
  // the occasional full-width value exercises every bit
  function automatic logic signed [SampleW-1:0] draw_sample(int unsigned shift);
    logic signed [SampleW-1:0] raw;
    raw = SampleW'($urandom);
    if ($urandom_range(0, 31) == 0) return raw;
    return raw >>> (shift + $urandom_range(0, 4));
  endfunction

  // sink side: random stall runs, released during calm phases
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !calm && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  // one sample pair per transaction; valid stays up across back-to-back items
  task automatic send_sample(input logic signed [SampleW-1:0] xs,
                             input logic signed [SampleW-1:0] ys);
    int gap;
    in_valid <= 1'b1;
    x_sample <= xs;
    y_sample <= ys;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (checked != sent);
  endtask

  // setup then access phase; the checker watches reads of the gain register
  task automatic apb_access(input logic write, input logic [PaddrW-1:0] addr,
                            input logic [PdataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // new gain with junk in the unused upper bits, then read it back
  task automatic set_gain(input logic [GainW-1:0] g);
    apb_access(1'b1, GAIN_ADDR, {(PdataW-GainW)'($urandom), g});
    apb_access(1'b0, GAIN_ADDR, '0);
    gain_writes++;
  endtask

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d of %0d results seen", cycles, checked, sent);
    $display("magnetometer_minmax_calibration_tb failed");
    $finish;
  end

  initial begin
    logic [GainW-1:0] g;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gain and tiny readings: the first pairs collapse y to a point, so the
    // y span is flat and the ratio is reported invalid until later pairs open it
    apb_access(1'b0, GAIN_ADDR, '0);
    send_sample(0, 0);
    send_sample(0, 0);
    send_sample(-5, 0);
    send_sample(4, 3);
    send_sample(0, -1);
    drain();

    // write beyond the register map must leave the gain alone
    apb_access(1'b1, SPARE_ADDR, '1);
    apb_access(1'b0, GAIN_ADDR, '0);

    // zero gain: every scaled reading is zero whatever the raw value
    set_gain('0);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh5555, 16'shAAAA);
    send_sample(-1, -1);
    drain();

    // unit gain with the raw extremes and alternating bit patterns
    set_gain(8'd1);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'shAAAA, 16'sh5555);
    send_sample(1, -1);
    send_sample(0, 0);

    // random phases: gain per phase, reading width grows toward full scale
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       g = 8'd3;
        2:       g = '0;
        4:       g = 8'd128;
        5:       g = 8'd200;
        7:       g = '1;
        default: g = GainW'($urandom_range(1, 255));
      endcase
      set_gain(g);
      calm <= (p == 3 || p == 6);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_sample(draw_sample(PHASES - 1 - p), draw_sample(PHASES - 1 - p));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d sample pairs under %0d gain writes, %0d results checked", sent,
             gain_writes, checked);
    $display("%0d results with a flat y span, gain readback and out-of-map write covered",
             flat_spans);
    if (waiting != 0) $display("%0d expected results never arrived", waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("magnetometer_minmax_calibration_tb passed");
    end else begin
      $display("magnetometer_minmax_calibration_tb failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mmcal_pkg.sv
hw/rtl/magnetometer_minmax_calibration.sv
bench/magnetometer_minmax_calibration_checker.sv
bench/magnetometer_minmax_calibration_tb.sv
